@@ sv/frlwa_pkg.sv @@
// constants, widths and the interval table for the frame rate limiter
// with window average; used by frame_rate_limiter_window_average_unit
// no dependencies
`default_nettype none

package frlwa_pkg;

    localparam int WINDOW       = 10;
    localparam int MIN_RATE     = 1;
    localparam int MAX_RATE     = 60;
    localparam int DEFAULT_RATE = 30;
    localparam int MS_PER_S     = 1000;

    localparam int RATE_W     = 6;
    localparam int INTERVAL_W = 10;
    localparam int NOW_W      = 32;
    localparam int GAP_W      = 32;
    localparam int SUM_W      = 36;
    localparam int FPS_W      = 22;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // 14.8 rate: window * 1000 * 256 / sum
    localparam longint DIVIDEND = longint'(WINDOW) * MS_PER_S * 256;
    localparam int     DIV_W    = $clog2(DIVIDEND + 1);
    localparam int     CNT_W    = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] DIVIDEND_V = DIV_W'(DIVIDEND);

    localparam int DEFAULT_INTERVAL = MS_PER_S / DEFAULT_RATE;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(longint'(WINDOW) * DEFAULT_INTERVAL);

    // stream word widths, padded to whole bytes
    localparam int OUT_FIELDS_W = 1 + FPS_W + INTERVAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_FPS    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PACING_ENABLE = 1'd1;

    // request kinds
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_SENT  = 1'b1;

    // whole milliseconds per frame, indexed by rate; unused codes hold the end values
    localparam logic [INTERVAL_W-1:0] INTERVAL_TBL [64] = '{
        10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166, 10'd142,
        10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,  10'd66,
        10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,  10'd43,
        10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33,  10'd32,
        10'd31,   10'd30,   10'd29,  10'd28,  10'd27,  10'd27,  10'd26,  10'd25,
        10'd25,   10'd24,   10'd23,  10'd23,  10'd22,  10'd22,  10'd21,  10'd21,
        10'd20,   10'd20,   10'd20,  10'd19,  10'd19,  10'd18,  10'd18,  10'd18,
        10'd17,   10'd17,   10'd17,  10'd16,  10'd16,  10'd16,  10'd16,  10'd16
    };

endpackage

`default_nettype wire

@@ sv/frame_rate_limiter_window_average_unit.sv @@
// frame pacing gate with ten-frame average rate report
// the input is taken in idle; the add state, the bit-serial divider (22 quotient bits)
// and the done state follow before the result word is registered; no new input word is
// taken until then, and a stalled result word keeps the input closed until it is taken
// reset: asynchronous, active low; rate 30, pacing on, ring filled with 33 ms gaps
// depends on frlwa_pkg
`default_nettype none

module frame_rate_limiter_window_average_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [frlwa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [frlwa_pkg::RATE_W-1:0]         cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [frlwa_pkg::NOW_W-1:0]          s_tdata,  // now_ms
    input  wire logic                                 s_tuser,  // req_type
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // send_ok, measured_fps, interval_ms, zero pad
    output logic [frlwa_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import frlwa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg,    state_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                  enable_reg,   enable_next;
    logic [NOW_W-1:0]      last_reg,     last_next;
    logic [GAP_W-1:0]      ring_reg [WINDOW];
    logic [GAP_W-1:0]      ring_next [WINDOW];
    logic [SLOT_W-1:0]     slot_reg,     slot_next;
    logic [SUM_W-1:0]      sum_reg,      sum_next;
    logic [GAP_W-1:0]      gap_reg,      gap_next;
    logic                  upd_reg,      upd_next;
    logic                  ok_reg,       ok_next;
    logic [DIV_W-1:0]      rem_reg,      rem_next;
    logic [DIV_W-1:0]      quo_reg,      quo_next;
    logic [CNT_W-1:0]      cnt_reg,      cnt_next;
    logic                  mvalid_reg,   mvalid_next;
    logic [OUT_TDATA_W-1:0] mdata_reg,   mdata_next;

    logic                  accept;
    logic [GAP_W-1:0]      elapsed;
    logic [RATE_W-1:0]     rate_clamped;
    logic [DIV_W:0]        shifted;
    logic [SUM_W:0]        trial;
    logic [FPS_W-1:0]      fps;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign elapsed  = s_tdata - last_reg;

    always_comb
    begin
        if (cfg_data < RATE_W'(MIN_RATE))
            rate_clamped = RATE_W'(MIN_RATE);
        else if (cfg_data > RATE_W'(MAX_RATE))
            rate_clamped = RATE_W'(MAX_RATE);
        else
            rate_clamped = cfg_data;
    end

    // one restoring step: bring down the next dividend bit, try the subtract
    assign shifted = {rem_reg, DIVIDEND_V[cnt_reg]};
    assign trial   = {{(SUM_W - DIV_W){1'b0}}, shifted} - {1'b0, sum_reg};

    always_comb
    begin
        if (sum_reg == '0)
            fps = '0;
        else if (quo_reg > DIV_W'({FPS_W{1'b1}}))
            fps = {FPS_W{1'b1}};
        else
            fps = FPS_W'(quo_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        interval_next = interval_reg;
        enable_next   = enable_reg;
        last_next     = last_reg;
        ring_next     = ring_reg;
        slot_next     = slot_reg;
        sum_next      = sum_reg;
        gap_next      = gap_reg;
        upd_next      = upd_reg;
        ok_next       = ok_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET_FPS:    interval_next = INTERVAL_TBL[rate_clamped];
                REG_PACING_ENABLE: enable_next   = cfg_data[0];
                default:           ;
            endcase
        end

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    upd_next = 1'b0;
                    if (s_tuser == REQ_QUERY)
                        ok_next = !enable_reg || (elapsed >= GAP_W'(interval_reg));
                    else
                    begin
                        ok_next = 1'b0;
                        if (enable_reg)
                        begin
                            // retire the oldest gap now, add the new one next cycle
                            upd_next            = 1'b1;
                            gap_next            = elapsed;
                            last_next           = s_tdata;
                            sum_next            = sum_reg - SUM_W'(ring_reg[slot_reg]);
                            ring_next[slot_reg] = elapsed;
                            if (slot_reg == SLOT_W'(WINDOW - 1))
                                slot_next = '0;
                            else
                                slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (upd_reg)
                    sum_next = sum_reg + SUM_W'(gap_reg);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = CNT_W'(DIV_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!trial[SUM_W])
                begin
                    rem_next = DIV_W'(trial);
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = DIV_W'(shifted);
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_TDATA_W'({interval_reg, fps, ok_reg});
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            interval_reg <= INTERVAL_W'(DEFAULT_INTERVAL);
            enable_reg   <= 1'b1;
            last_reg     <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= GAP_W'(DEFAULT_INTERVAL);
            end
            slot_reg     <= '0;
            sum_reg      <= SUM_RESET;
            upd_reg      <= 1'b0;
            cnt_reg      <= '0;
            mvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            interval_reg <= interval_next;
            enable_reg   <= enable_next;
            last_reg     <= last_next;
            ring_reg     <= ring_next;
            slot_reg     <= slot_next;
            sum_reg      <= sum_next;
            upd_reg      <= upd_next;
            cnt_reg      <= cnt_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg   <= gap_next;
        ok_reg    <= ok_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        mdata_reg <= mdata_next;
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken again while an item is in flight");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> state_reg == ST_DONE)
        else $error("divider did not finish after its last step");

    a_query_keeps_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == REQ_QUERY) |=> $stable(sum_reg) && $stable(slot_reg))
        else $error("a query changed the gap window");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("ring slot beyond the window");

    a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
        interval_reg >= INTERVAL_W'(MS_PER_S / MAX_RATE)
        && interval_reg <= INTERVAL_W'(MS_PER_S / MIN_RATE))
        else $error("interval outside the rate limits");
`endif

endmodule

`default_nettype wire
